>>> design/ctw_pkg.sv
// types, type codes and the type merge function shared by the column type widening block
package ctw_pkg;

  typedef enum logic {
    OP_MERGE = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  // field type codes
  localparam logic [3:0] T_UNKNOWN = 4'd0;
  localparam logic [3:0] T_BOOL    = 4'd1;
  localparam logic [3:0] T_INT8    = 4'd2;
  localparam logic [3:0] T_INT64   = 4'd5;
  localparam logic [3:0] T_UINT8   = 4'd6;
  localparam logic [3:0] T_UINT64  = 4'd9;
  localparam logic [3:0] T_FLOAT32 = 4'd10;
  localparam logic [3:0] T_FLOAT80 = 4'd12;
  localparam logic [3:0] T_STRING  = 4'd13;

  // what the merge stage does with an item
  typedef enum logic [1:0] {
    K_CLEAR,
    K_MERGE,
    K_APPEND,
    K_OVERFLOW
  } kind_t;

  typedef struct packed {
    op_t        opcode;
    logic [3:0] field_type;
    logic       last_field;
  } item_t;

  typedef struct packed {
    logic [5:0] column_index;
    logic [3:0] merged_type;
    logic [6:0] columns_known;
    logic       overflow;
  } result_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] field_type;
    logic [6:0] columns_known;
  } stage_t;

  function automatic logic is_sint(input logic [3:0] t);
    return (t >= T_INT8) && (t <= T_INT64);
  endfunction

  function automatic logic is_uint(input logic [3:0] t);
    return (t >= T_UINT8) && (t <= T_UINT64);
  endfunction

  function automatic logic is_fp_type(input logic [3:0] t);
    return (t >= T_FLOAT32) && (t <= T_FLOAT80);
  endfunction

  // width class 0..3 for 8/16/32/64 bits
  function automatic logic [1:0] width_class(input logic [3:0] t);
    logic [3:0] d;
    d = is_sint(t) ? (t - T_INT8) : (t - T_UINT8);
    return d[1:0];
  endfunction

  function automatic logic [3:0] merge_type(input logic [3:0] a, input logic [3:0] l);
    logic [1:0] wa;
    logic [1:0] wl;
    logic [1:0] w;
    logic [3:0] r;
    wa = width_class(a);
    wl = width_class(l);
    w  = (wa > wl) ? wa : wl;
    if (l == T_UNKNOWN) begin
      r = a;
    end else if (a == T_UNKNOWN) begin
      r = l;
    end else if (a == T_STRING) begin
      r = T_STRING;
    end else if (a == T_BOOL) begin
      r = (l == T_BOOL) ? T_BOOL : T_STRING;
    end else if (is_sint(a) || is_uint(a)) begin
      if (is_sint(l) || is_uint(l)) begin
        // unsigned only when both are unsigned, else signed
        r = (is_uint(a) && is_uint(l)) ? (T_UINT8 + {2'b00, w}) : (T_INT8 + {2'b00, w});
      end else if (l == T_BOOL) begin
        r = T_STRING;
      end else begin
        r = l;
      end
    end else if (is_fp_type(a)) begin
      r = ((l == T_STRING) || (l == T_BOOL)) ? T_STRING : a;
    end else begin
      r = a;
    end
    return r;
  endfunction

endpackage

>>> design/ctw_ram.sv
// generic single write port, single read port ram with registered read
module ctw_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/ctw_front.sv
// front stage: line position and column count tracking, item classification, input register
module ctw_front
  import ctw_pkg::*;
#(
  parameter int MAX_COLUMNS = 64,
  localparam int CW = $clog2(MAX_COLUMNS + 1),
  localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  item_t         item,
  output logic          s1_valid,
  output stage_t        s1_ctl,
  output logic [AW-1:0] s1_pos,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr
);

  logic [CW-1:0] field_position;
  logic [CW-1:0] column_count;
  logic [CW-1:0] position_next;
  logic [CW-1:0] count_next;
  logic [3:0]    ftype;
  stage_t        ctl;

  always_comb begin
    // codes above string count as unknown
    ftype = (item.field_type > T_STRING) ? T_UNKNOWN : item.field_type;
    ctl.field_type = ftype;
    ctl.kind = K_CLEAR;
    count_next = column_count;
    position_next = field_position;
    if (item.opcode == OP_CLEAR) begin
      ctl.kind = K_CLEAR;
      count_next = '0;
      position_next = '0;
    end else begin
      if (field_position >= CW'(MAX_COLUMNS)) begin
        ctl.kind = K_OVERFLOW;
      end else if (field_position < column_count) begin
        ctl.kind = K_MERGE;
      end else begin
        ctl.kind = K_APPEND;
        count_next = field_position + CW'(1);
      end
      if (item.last_field) begin
        position_next = '0;
      end else if (field_position < CW'(MAX_COLUMNS)) begin
        position_next = field_position + CW'(1);
      end
    end
    ctl.columns_known = 7'(count_next);
  end

  assign rd_en   = accept && (ctl.kind == K_MERGE);
  assign rd_addr = field_position[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      field_position <= '0;
      column_count   <= '0;
      s1_valid       <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        field_position <= position_next;
        column_count   <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl <= ctl;
      s1_pos <= field_position[AW-1:0];
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (column_count <= CW'(MAX_COLUMNS)) && (field_position <= CW'(MAX_COLUMNS)))
    else $error("column count or field position beyond capacity");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    accept && (item.opcode == OP_MERGE) && !item.last_field &&
    (field_position < CW'(MAX_COLUMNS))
    |=> field_position == $past(field_position) + CW'(1))
    else $error("field position did not advance");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    accept && (ctl.kind == K_APPEND) |=> column_count == $past(field_position) + CW'(1))
    else $error("append did not extend the column count");
`endif

endmodule

>>> design/ctw_merge.sv
// merge stage: forwarding of the last write, type merge, table write and result register
module ctw_merge
  import ctw_pkg::*;
#(
  parameter int MAX_COLUMNS = 64,
  localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s1_valid,
  input  stage_t        s1_ctl,
  input  logic [AW-1:0] s1_pos,
  input  logic [3:0]    rd_data,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [3:0]    wr_data,
  output logic          done,
  output result_t       result
);

  logic          fwd_valid;
  logic [AW-1:0] fwd_addr;
  logic [3:0]    fwd_data;
  logic [3:0]    col_type;
  logic [3:0]    merged;
  logic          writes;
  result_t       res;

  always_comb begin
    // a write at the edge of our read is not in rd_data yet
    col_type = (fwd_valid && (fwd_addr == s1_pos)) ? fwd_data : rd_data;
    unique case (s1_ctl.kind)
      K_MERGE:    merged = merge_type(col_type, s1_ctl.field_type);
      K_APPEND:   merged = s1_ctl.field_type;
      K_CLEAR:    merged = T_UNKNOWN;
      K_OVERFLOW: merged = T_UNKNOWN;
    endcase
    writes = (s1_ctl.kind == K_MERGE) || (s1_ctl.kind == K_APPEND);
    res.column_index  = writes ? 6'(s1_pos) : 6'd0;
    res.merged_type   = merged;
    res.columns_known = s1_ctl.columns_known;
    res.overflow      = (s1_ctl.kind == K_OVERFLOW);
  end

  assign wr_en   = s1_valid && writes;
  assign wr_addr = s1_pos;
  assign wr_data = merged;

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      done      <= s1_valid;
      fwd_valid <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    result   <= res;
    fwd_addr <= s1_pos;
    fwd_data <= merged;
  end

`ifndef ASSERT_OFF
  a_type_range: assert property (@(posedge clk) disable iff (rst)
    done |-> result.merged_type <= T_STRING)
    else $error("merged type code out of range");
`endif

endmodule

>>> design/column_type_widening.sv
// top level of the column type widening block
//
//   channel | signals                 | handshake
//   --------+-------------------------+---------------------------------------
//   input   | start, busy, item       | taken at an edge with start high, busy low
//   result  | done, result            | done high for one cycle, no back pressure
//
// one item per cycle sustained; busy stays low
// the result passes the registered column table read, then the merge and the
//   result register
// a field that hits the column written by the item just before is served by
//   a one-entry forwarding register, so back to back fields on one column work
// reset clears position, column count and strobes; the column table itself is
//   not swept and is only read at columns written since the last clear
// the receiver cannot stall, so nothing is held back on the result side
module column_type_widening
  import ctw_pkg::*;
#(
  parameter int MAX_COLUMNS = 64
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  logic          accept;
  logic          s1_valid;
  stage_t        s1_ctl;
  logic [AW-1:0] s1_pos;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [3:0]    rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [3:0]    wr_data;

  // every item fits the single pass, so there is never a reason to hold off
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // position and count bookkeeping, item classification, table read issue
  ctw_front #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .item    (item),
    .s1_valid(s1_valid),
    .s1_ctl  (s1_ctl),
    .s1_pos  (s1_pos),
    .rd_en   (rd_en),
    .rd_addr (rd_addr)
  );

  // per-column inferred type table
  ctw_ram #(
    .WIDTH(4),
    .DEPTH(MAX_COLUMNS)
  ) u_types (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // widening merge, write back and result register
  ctw_merge #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_merge (
    .clk     (clk),
    .rst     (rst),
    .s1_valid(s1_valid),
    .s1_ctl  (s1_ctl),
    .s1_pos  (s1_pos),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .done    (done),
    .result  (result)
  );

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 done)
    else $error("result did not follow item after two cycles");

  a_overflow_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.overflow |-> (result.column_index == 6'd0) &&
                                (result.merged_type == T_UNKNOWN))
    else $error("overflow result carries a column or type");
`endif

endmodule

>>> tb/tb_top.sv
// testbench for the column type widening block: directed merge rules, capacity and random files
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ctw_pkg::*;

  localparam int MAX_COLS = 64;
  // bound on the line width the stimulus builds, 16 fields past capacity
  localparam int MAX_LINE = 80;
  // cycles with nothing taken and nothing returned before the run is called hung
  localparam int IDLE_LIMIT = 200;
  // margin at the end of the run after the last pending result
  localparam int DRAIN_CYCLES = 8;

  // coarse type classes used by the predictor
  typedef enum {
    C_UNK,
    C_BOOL,
    C_SINT,
    C_UINT,
    C_FLT,
    C_STR
  } tclass_t;

  // what kind of values a random column mostly holds
  typedef enum {
    FAM_SINT,
    FAM_UINT,
    FAM_INT,
    FAM_FLOAT,
    FAM_BOOL,
    FAM_SPARSE,
    FAM_ANY
  } family_t;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  item_t   item;
  logic    done;
  result_t result;

  column_type_widening #(
    .MAX_COLUMNS(MAX_COLS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .item  (item),
    .done  (done),
    .result(result)
  );

  // predictor copy of the column table
  logic [3:0]  col_type [MAX_COLS];
  int unsigned col_count;
  int unsigned field_pos;

  // expected results, oldest first
  result_t merge_results_due [$];

  int unsigned items_sent;
  int unsigned clears_sent;
  int unsigned results_checked;
  int unsigned overflows_seen;
  int unsigned mismatches;
  int unsigned idle_cycles;
  bit          gaps_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  function automatic tclass_t classify(input logic [3:0] t);
    if (t == T_UNKNOWN) return C_UNK;
    if (t == T_BOOL) return C_BOOL;
    if (t >= T_INT8 && t <= T_INT64) return C_SINT;
    if (t >= T_UINT8 && t <= T_UINT64) return C_UINT;
    if (t >= T_FLOAT32 && t <= T_FLOAT80) return C_FLT;
    return C_STR;
  endfunction

  // width step 0..3 for 8/16/32/64-bit integers
  function automatic logic [1:0] int_width(input logic [3:0] t);
    return (classify(t) == C_SINT) ? 2'(t - T_INT8) : 2'(t - T_UINT8);
  endfunction

  // widen a column type by one field type
  function automatic logic [3:0] widen_type(input logic [3:0] col, input logic [3:0] fld);
    tclass_t    cc;
    tclass_t    fc;
    logic [1:0] wc;
    logic [1:0] wf;
    logic [1:0] w;
    cc = classify(col);
    fc = classify(fld);
    // an unknown field never changes anything, an unknown column takes the field
    if (fc == C_UNK) return col;
    if (cc == C_UNK) return fld;
    if (cc == C_STR || fc == C_STR) return T_STRING;
    // bool only survives against bool
    if (cc == C_BOOL || fc == C_BOOL) return (cc == fc) ? T_BOOL : T_STRING;
    // a float column keeps its own width, an integer column gives way to the float
    if (cc == C_FLT) return col;
    if (fc == C_FLT) return fld;
    wc = int_width(col);
    wf = int_width(fld);
    w  = (wc > wf) ? wc : wf;
    // unsigned only when both sides are unsigned
    return (cc == C_UINT && fc == C_UINT) ? 4'(T_UINT8 + w) : 4'(T_INT8 + w);
  endfunction

  // apply one item to the predictor table and return the result it causes
  function automatic result_t widen_column(input item_t it);
    result_t     r;
    logic [3:0]  ft;
    int unsigned pos;
    r   = '0;
    pos = field_pos;
    if (it.opcode == OP_CLEAR) begin
      col_count = 0;
      field_pos = 0;
      return r;
    end
    // codes past string read as unknown
    ft = (it.field_type > T_STRING) ? T_UNKNOWN : it.field_type;
    if (pos >= MAX_COLS) begin
      r.overflow = 1'b1;
    end else if (pos < col_count) begin
      col_type[pos]  = widen_type(col_type[pos], ft);
      r.column_index = 6'(pos);
      r.merged_type  = col_type[pos];
    end else begin
      // first field seen in this column appends it
      col_type[pos]  = ft;
      col_count      = pos + 1;
      r.column_index = 6'(pos);
      r.merged_type  = ft;
    end
    // position restarts after a line end, otherwise saturates at capacity
    if (it.last_field) begin
      field_pos = 0;
    end else if (pos < MAX_COLS) begin
      field_pos = pos + 1;
    end
    r.columns_known = 7'(col_count);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // driving
  // --------------------------------------------------------------------------

  function automatic item_t make_item(input op_t op, input logic [3:0] ft, input logic last);
    item_t it;
    it.opcode     = op;
    it.field_type = ft;
    it.last_field = last;
    return it;
  endfunction

  // present one item, hold it until taken, then log what it should produce
  task automatic send_item(input item_t it);
    result_t want;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = widen_column(it);
    merge_results_due.insert(merge_results_due.size(), want);
    items_sent++;
    if (it.opcode == OP_CLEAR) clears_sent++;
  endtask

  task automatic send_field(input logic [3:0] ft, input logic last);
    send_item(make_item(OP_MERGE, ft, last));
  endtask

  // clear with junk in the ignored fields
  task automatic send_clear();
    send_item(make_item(OP_CLEAR, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
  endtask

  // mostly types of the column's family, sometimes any code at all
  function automatic logic [3:0] pick_type(input family_t fam);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) return 4'($urandom_range(0, 15));
    case (fam)
      FAM_SINT: begin
        return 4'(T_INT8 + $urandom_range(0, 3));
      end
      FAM_UINT: begin
        return 4'(T_UINT8 + $urandom_range(0, 3));
      end
      FAM_INT: begin
        return 4'(T_INT8 + $urandom_range(0, 7));
      end
      FAM_FLOAT: begin
        return (roll < 40) ? 4'(T_INT8 + $urandom_range(0, 7))
                           : 4'(T_FLOAT32 + $urandom_range(0, 2));
      end
      FAM_BOOL: begin
        return (roll < 85) ? T_BOOL : T_UNKNOWN;
      end
      FAM_SPARSE: begin
        return (roll < 55) ? T_UNKNOWN : 4'(T_INT8 + $urandom_range(0, 7));
      end
      default: begin
        return 4'($urandom_range(0, 13));
      end
    endcase
  endfunction

  // one random file: a column layout, then lines that mostly follow it
  task automatic run_file();
    family_t     fam [MAX_LINE];
    int unsigned ncols;
    int unsigned nlines;
    int unsigned len;
    bit          unterminated;
    // rare wide files come close to capacity or run past it
    ncols  = ($urandom_range(0, 19) == 0) ? $urandom_range(55, 70) : $urandom_range(1, 10);
    nlines = (ncols > 40) ? $urandom_range(1, 3) : $urandom_range(3, 14);
    for (int c = 0; c < MAX_LINE; c++) begin
      fam[c] = family_t'($urandom_range(0, 6));
    end
    for (int l = 0; l < nlines; l++) begin
      len = ($urandom_range(0, 99) < 80) ? ncols : $urandom_range(1, ncols + 3);
      // now and then a line never ends, so the next one runs on into it
      unterminated = ($urandom_range(0, 29) == 0);
      for (int f = 0; f < len; f++) begin
        // a clear in the middle of a line breaks it off
        if ($urandom_range(0, 199) == 0) send_clear();
        send_field(pick_type(fam[f]), (f == len - 1) && !unterminated);
      end
    end
    // most files end with a clear, the rest pile onto the same table
    if ($urandom_range(0, 3) != 0) send_clear();
  endtask

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch at %0t: %s, got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && done !== 1'b0) begin
      if (merge_results_due.size() == 0) begin
        report_mismatch("result with no item pending", 0, 0);
      end else begin
        want = merge_results_due.pop_front();
        results_checked++;
        if (want.overflow) overflows_seen++;
        if (result.column_index !== want.column_index)
          report_mismatch("column_index", result.column_index, want.column_index);
        if (result.merged_type !== want.merged_type)
          report_mismatch("merged_type", result.merged_type, want.merged_type);
        if (result.columns_known !== want.columns_known)
          report_mismatch("columns_known", result.columns_known, want.columns_known);
        if (result.overflow !== want.overflow)
          report_mismatch("overflow", result.overflow, want.overflow);
      end
    end
  end

  // watchdog: a run where nothing moves for too long is hung
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: nothing taken or returned for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // one column at a time through every merge rule, then lines of up to three columns
  task automatic test_merge_rules();
    send_clear();
    send_field(T_INT8, 1'b1);                 // append into an empty table
    send_field(4'(T_UINT8 + 1), 1'b1);        // int8 with uint16 gives int16
    send_field(T_UINT64, 1'b1);               // mixed sign at the widest width
    send_field(T_UNKNOWN, 1'b1);              // unknown leaves the column alone
    send_field(4'd15, 1'b1);                  // invalid code reads as unknown
    send_field(4'(T_FLOAT32 + 1), 1'b1);      // float beats integer
    send_field(4'(T_INT8 + 2), 1'b1);         // integer into a float column
    send_field(T_FLOAT80, 1'b1);              // float column keeps its width
    send_field(T_BOOL, 1'b1);                 // bool against float is string
    send_field(T_INT8, 1'b1);                 // string absorbs everything
    send_item(make_item(OP_CLEAR, T_UNKNOWN, 1'b0));
    send_field(T_BOOL, 1'b0);                 // columns 0..2 appended in one line
    send_field(4'd14, 1'b0);                  // invalid code appends as unknown
    send_field(T_UINT8, 1'b1);
    send_field(T_BOOL, 1'b0);                 // bool stays bool
    send_field(4'(T_UINT8 + 2), 1'b0);        // unknown column takes uint32
    send_field(4'(T_UINT8 + 1), 1'b1);        // both unsigned: the wider
    send_field(T_INT8, 1'b0);                 // bool against int is string
    send_field(T_BOOL, 1'b0);                 // int against bool is string
    send_field(T_STRING, 1'b1);
    send_item(make_item(OP_CLEAR, T_STRING, 1'b1));
    send_field(T_FLOAT32, 1'b1);
    send_field(T_STRING, 1'b1);               // string into a float column
    send_field(T_INT64, 1'b0);                // string absorbs int64, uint8 appends column 1
    send_field(T_UINT8, 1'b1);
  endtask

  // lines that fill the table and run past its capacity
  task automatic test_capacity();
    send_clear();
    // 70 fields: the last six overflow and the position saturates
    for (int f = 0; f < 70; f++) begin
      send_field(pick_type(FAM_INT), f == 69);
    end
    for (int f = 0; f < 3; f++) begin
      send_field(pick_type(FAM_FLOAT), f == 2);
    end
    // exactly full line
    for (int f = 0; f < MAX_COLS; f++) begin
      send_field(pick_type(FAM_ANY), f == MAX_COLS - 1);
    end
    // line end carried by an overflowing field
    for (int f = 0; f < MAX_COLS + 2; f++) begin
      send_field(pick_type(FAM_UINT), f == MAX_COLS + 1);
    end
    send_field(T_BOOL, 1'b1);
    send_clear();
  endtask

  // random files with idle bursts switched on and off
  task automatic test_random_files(input int unsigned count);
    int unsigned stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      run_file();
    end
  endtask

  // random files at full rate to close the run
  task automatic test_back_to_back(input int unsigned count);
    int unsigned stop_at;
    stop_at = items_sent + count;
    gaps_on = 1'b0;
    while (items_sent < stop_at) begin
      run_file();
    end
  endtask

  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    item            = '0;
    col_count       = 0;
    field_pos       = 0;
    items_sent      = 0;
    clears_sent     = 0;
    results_checked = 0;
    overflows_seen  = 0;
    mismatches      = 0;
    gaps_on         = 1'b1;
    for (int c = 0; c < MAX_COLS; c++) begin
      col_type[c] = T_UNKNOWN;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_merge_rules();
    test_capacity();
    test_random_files(700);
    test_back_to_back(150);

    start <= 1'b0;
    // wait out every pending result, then a few cycles for strays
    while (merge_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d items sent (%0d clears), %0d results checked, %0d past capacity, %0d mismatches",
             items_sent, clears_sent, results_checked, overflows_seen, mismatches);
    $display("covered every merge rule, invalid codes, capacity overflow and idle bursts");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
